FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker in hdl/rls_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every edge, reset included.
`define RLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
// Checked only while the active-low reset is released.
`define RLS_ASSERT_RUN(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`endif

FILE: hdl/rls_pkg.sv
// Package with types, codes and constants of the request statistics block.
package rls_pkg;

    localparam int DEF_RING_DEPTH = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam int LAT_W  = 47;
    localparam int CNT_W  = 64;
    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 576;
    localparam int RES_W       = 572;

    localparam logic [15:0] STATUS_GOOD_LO = 16'd200;
    localparam logic [15:0] STATUS_GOOD_HI = 16'd400;
    localparam int PCT_95  = 95;
    localparam int PCT_99  = 99;
    localparam int PCT_ALL = 100;

    localparam logic [1:0] CMD_RECORD   = 2'd0;
    localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // One queued operation, already decoded by the front end.
    typedef struct packed {
        logic [1:0]       kind;
        logic             good;
        logic [LAT_W-1:0] lat;
        logic [31:0]      bytes_out;
        logic [31:0]      bytes_in;
    } t_op;

    // Snapshot result; the last member sits in the lowest bits.
    typedef struct packed {
        logic [LAT_W-1:0] latency_p99;
        logic [LAT_W-1:0] latency_p95;
        logic [LAT_W-1:0] latency_max;
        logic [LAT_W-1:0] latency_min;
        logic [CNT_W-1:0] latency_total;
        logic [CNT_W-1:0] received_total;
        logic [CNT_W-1:0] sent_total;
        logic [CNT_W-1:0] bad_requests;
        logic [CNT_W-1:0] good_requests;
        logic [CNT_W-1:0] req_total;
    } t_result;

endpackage

FILE: hdl/rls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rls_front.sv
// Front end: accepts input words, decodes the command and classifies requests.
module rls_front import rls_pkg::*; (
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    input  logic [IN_TUSER_W-1:0] i_s_tuser,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_op                   o_q_op
);

    logic [15:0] resp_status;
    logic [47:0] latency_us;

    assign resp_status = i_s_tdata[15:0];
    assign latency_us  = i_s_tdata[63:16];
    assign o_s_tready  = !i_q_full;

    always_comb begin
        o_q_op.kind      = i_s_tuser;
        o_q_op.good      = (resp_status >= STATUS_GOOD_LO) && (resp_status < STATUS_GOOD_HI);
        // Negative latencies count as zero.
        o_q_op.lat       = latency_us[47] ? '0 : latency_us[LAT_W-1:0];
        o_q_op.bytes_out = i_s_tdata[95:64];
        o_q_op.bytes_in  = i_s_tdata[127:96];
        unique case (i_s_tuser)
            CMD_RECORD, CMD_SNAPSHOT, CMD_CLEAR: o_q_push = i_s_tvalid && !i_q_full;
            CMD_UNUSED:                          o_q_push = 1'b0;
            default:                             o_q_push = 1'b0;
        endcase
    end

endmodule

FILE: hdl/rls_fifo.sv
// Short operation queue between the front end and the back end.
module rls_fifo import rls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_push_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_pop_op,
    output logic o_valid
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_entry [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [NW-1:0] r_cnt;

    assign o_full   = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_pop_op = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/rls_back.sv
// Back end: statistics registers, sample ring and percentile rank selection.
module rls_back import rls_pkg::*; #(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_op     i_q_op,
    output logic    o_q_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = CW + 7;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAND = 3'd1;
    localparam logic [2:0] S_CLAT = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_req, r_good, r_bad, r_sent, r_recv, r_lsum;
    logic [LAT_W-1:0] r_min, r_max;
    logic             r_any;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_fill;
    logic [AW-1:0]    r_j;
    logic [CW-1:0]    r_ia;
    logic             r_pend;
    logic [LAT_W-1:0] r_cand;
    logic [CW-1:0]    r_lt, r_le;
    logic             r_f95, r_f99;
    logic [LAT_W-1:0] r_p95, r_p99;
    logic             r_ovalid;
    t_result          r_res;

    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [LAT_W-1:0] ram_rdata;
    logic [CNT_W:0]   lsum_ext;
    logic [PW-1:0]    n95, n99, lt100, le100;
    logic             hit95, hit99, load;

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign ram_we    = o_q_pop && (i_q_op.kind == CMD_RECORD);
    assign ram_raddr = (r_state == S_CAND) ? r_j : r_ia[AW-1:0];
    assign lsum_ext  = {1'b0, r_lsum} + (CNT_W+1)'(i_q_op.lat);

    // Rank k = ceil(n*p/100): the candidate has that rank when
    // 100*lt < p*n <= 100*le, with lt and le counts of smaller and not larger.
    assign n95   = PW'(r_fill) * PW'(PCT_95);
    assign n99   = PW'(r_fill) * PW'(PCT_99);
    assign lt100 = PW'(r_lt) * PW'(PCT_ALL);
    assign le100 = PW'(r_le) * PW'(PCT_ALL);
    assign hit95 = (lt100 < n95) && (n95 <= le100);
    assign hit99 = (lt100 < n99) && (n99 <= le100);
    assign load  = (r_state == S_DONE) && (!r_ovalid || i_res_ready);

    rls_ram #(.WIDTH(LAT_W), .DEPTH(RING_DEPTH), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (i_q_op.lat),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_req    <= '0;
            r_good   <= '0;
            r_bad    <= '0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_lsum   <= '0;
            r_any    <= 1'b0;
            r_head   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        unique case (i_q_op.kind)
                            CMD_RECORD: begin
                                r_req  <= r_req + 1'b1;
                                r_sent <= r_sent + CNT_W'(i_q_op.bytes_out);
                                r_recv <= r_recv + CNT_W'(i_q_op.bytes_in);
                                r_lsum <= lsum_ext[CNT_W] ? '1 : lsum_ext[CNT_W-1:0];
                                if (i_q_op.good) begin
                                    r_good <= r_good + 1'b1;
                                end else begin
                                    r_bad <= r_bad + 1'b1;
                                end
                                r_any <= 1'b1;
                                r_head <= (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                                if (r_fill != CW'(RING_DEPTH)) begin
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_req  <= '0;
                                r_good <= '0;
                                r_bad  <= '0;
                                r_sent <= '0;
                                r_recv <= '0;
                                r_lsum <= '0;
                                r_any  <= 1'b0;
                                r_head <= '0;
                                r_fill <= '0;
                            end
                            CMD_SNAPSHOT: begin
                                r_state <= (r_fill == '0) ? S_DONE : S_CAND;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CAND: r_state <= S_CLAT;
                S_CLAT: r_state <= S_SCAN;
                S_SCAN: begin
                    if ((r_ia == r_fill) && !r_pend) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if ((r_f95 || hit95) && (r_f99 || hit99)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CAND;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload and selection datapath.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_op.kind == CMD_RECORD)) begin
            if (!r_any || (i_q_op.lat < r_min)) begin
                r_min <= i_q_op.lat;
            end
            if (!r_any || (i_q_op.lat > r_max)) begin
                r_max <= i_q_op.lat;
            end
        end
        if (o_q_pop && (i_q_op.kind == CMD_SNAPSHOT)) begin
            r_j   <= '0;
            r_f95 <= 1'b0;
            r_f99 <= 1'b0;
            r_p95 <= '0;
            r_p99 <= '0;
        end
        if (r_state == S_CLAT) begin
            r_cand <= ram_rdata;
            r_ia   <= '0;
            r_pend <= 1'b0;
            r_lt   <= '0;
            r_le   <= '0;
        end
        if (r_state == S_SCAN) begin
            if (r_ia != r_fill) begin
                r_ia   <= r_ia + 1'b1;
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                if (ram_rdata < r_cand) begin
                    r_lt <= r_lt + 1'b1;
                end
                if (ram_rdata <= r_cand) begin
                    r_le <= r_le + 1'b1;
                end
            end
        end
        if (r_state == S_EVAL) begin
            r_j <= r_j + 1'b1;
            if (!r_f95 && hit95) begin
                r_f95 <= 1'b1;
                r_p95 <= r_cand;
            end
            if (!r_f99 && hit99) begin
                r_f99 <= 1'b1;
                r_p99 <= r_cand;
            end
        end
        if (load) begin
            r_res.req_total      <= r_req;
            r_res.good_requests  <= r_good;
            r_res.bad_requests   <= r_bad;
            r_res.sent_total     <= r_sent;
            r_res.received_total <= r_recv;
            r_res.latency_total  <= r_lsum;
            r_res.latency_min    <= r_any ? r_min : '0;
            r_res.latency_max    <= r_any ? r_max : '0;
            r_res.latency_p95    <= r_p95;
            r_res.latency_p99    <= r_p99;
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

FILE: hdl/request_latency_statistics.sv
// A record word is pushed into the queue and updates the totals when the back end
// pops it while idle; records, clears and snapshots pass through a four-word queue,
// one per cycle while the queue is not full. A snapshot holds the back end over n
// ring samples (up to RING_DEPTH) while the rank scan reads the ring RAM once a cycle.
// Reset is synchronous and active low; it clears all totals, the queue and the
// ring pointers at once. Ring contents are not cleared and need no sweep.
module request_latency_statistics import rls_pkg::*; #(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // resp_status[15:0], latency_us[63:16], bytes_out[95:64], bytes_in[127:96]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // command[1:0]: 0 record, 1 snapshot, 2 clear
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // req_total[63:0], good_requests[127:64], bad_requests[191:128],
    // sent_total[255:192], received_total[319:256], latency_total[383:320],
    // latency_min[430:384], latency_max[477:431], latency_p95[524:478],
    // latency_p99[571:525], zero padding above
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // Decoded operations flow from the front end through the queue, so a record word
    // is taken while a snapshot result waits on the output, until the queue is full.
    logic    q_full;
    logic    q_push;
    t_op     q_in_op;
    logic    q_valid;
    logic    q_pop;
    t_op     q_out_op;
    t_result res;

    rls_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_op     (q_in_op)
    );

    rls_fifo u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (q_in_op),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_pop_op  (q_out_op),
        .o_valid   (q_valid)
    );

    // The back end owns the statistics and the sample ring. A snapshot result
    // stays in its output register until the sink takes it.
    rls_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_out_op),
        .o_q_pop     (q_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

FILE: hdl/rls_checker.sv
// Port-level checker for the request statistics block, bound to the top level.
`include "assert_macros.svh"
module rls_checker import rls_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    `RLS_ASSERT_ALWAYS(a_ready_after_reset, i_clk, !i_rst_n |=> o_s_tready)
    `RLS_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !o_m_tvalid)
    `RLS_ASSERT_RUN(a_valid_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `RLS_ASSERT_RUN(a_data_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))

endmodule

bind request_latency_statistics rls_checker u_rls_checker (.*);

FILE: sim/rls_checker.sv
// Checker for the request statistics block: predicts snapshot words and compares them.
`timescale 1ns / 100ps
module rls_scoreboard import rls_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int DEPTH = DEF_RING_DEPTH;

    // Mirror of the block's statistics.
    logic [CNT_W-1:0] req_cnt, good_cnt, bad_cnt, sent_sum, recv_sum, lat_sum;
    logic [LAT_W-1:0] lat_lo, lat_hi;
    logic             lat_seen;
    logic [LAT_W-1:0] lat_ring [DEPTH];
    int               ring_wr, ring_cnt;

    t_result snap_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string field, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic clear_stats();
        req_cnt  = '0;
        good_cnt = '0;
        bad_cnt  = '0;
        sent_sum = '0;
        recv_sum = '0;
        lat_sum  = '0;
        lat_lo   = '0;
        lat_hi   = '0;
        lat_seen = 1'b0;
        ring_wr  = 0;
        ring_cnt = 0;
    endtask

    task automatic add_request(input logic [15:0] status, input logic [47:0] lat_raw,
                               input logic [31:0] b_out, input logic [31:0] b_in);
        logic [LAT_W-1:0] lat;
        logic [CNT_W:0]   wide;
        req_cnt  = req_cnt + 1;
        sent_sum = sent_sum + b_out;
        recv_sum = recv_sum + b_in;
        // Negative latencies count as zero everywhere and never reach the sum.
        lat = lat_raw[47] ? '0 : lat_raw[LAT_W-1:0];
        if (lat != 0) begin
            wide    = {1'b0, lat_sum} + lat;
            lat_sum = wide[CNT_W] ? '1 : wide[CNT_W-1:0];
        end
        if (status >= STATUS_GOOD_LO && status < STATUS_GOOD_HI) good_cnt = good_cnt + 1;
        else bad_cnt = bad_cnt + 1;
        if (!lat_seen) begin
            lat_lo   = lat;
            lat_hi   = lat;
            lat_seen = 1'b1;
        end else begin
            if (lat < lat_lo) lat_lo = lat;
            if (lat > lat_hi) lat_hi = lat;
        end
        lat_ring[ring_wr] = lat;
        ring_wr = (ring_wr + 1) % DEPTH;
        if (ring_cnt < DEPTH) ring_cnt++;
    endtask

    // Sorts the filled part of the ring and picks the samples at both ranks.
    task automatic rank_latencies(output logic [LAT_W-1:0] p95, output logic [LAT_W-1:0] p99);
        logic [LAT_W-1:0] sorted [DEPTH];
        logic [LAT_W-1:0] v;
        int j;
        p95 = '0;
        p99 = '0;
        if (ring_cnt > 0) begin
            for (int i = 0; i < ring_cnt; i++) begin
                v = lat_ring[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            p95 = sorted[(ring_cnt * PCT_95 + PCT_ALL - 1) / PCT_ALL - 1];
            p99 = sorted[(ring_cnt * PCT_99 + PCT_ALL - 1) / PCT_ALL - 1];
        end
    endtask

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            clear_stats();
            snap_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[RES_W-1:0]);
                if (snap_q.size() == 0) begin
                    report_mismatch("unexpected word", got.req_total, '0);
                end else begin
                    want = snap_q.pop_front();
                    if (got.req_total != want.req_total)
                        report_mismatch("req_total", got.req_total, want.req_total);
                    if (got.good_requests != want.good_requests)
                        report_mismatch("good_requests", got.good_requests, want.good_requests);
                    if (got.bad_requests != want.bad_requests)
                        report_mismatch("bad_requests", got.bad_requests, want.bad_requests);
                    if (got.sent_total != want.sent_total)
                        report_mismatch("sent_total", got.sent_total, want.sent_total);
                    if (got.received_total != want.received_total)
                        report_mismatch("received_total", got.received_total,
                                        want.received_total);
                    if (got.latency_total != want.latency_total)
                        report_mismatch("latency_total", got.latency_total, want.latency_total);
                    if (got.latency_min != want.latency_min)
                        report_mismatch("latency_min", got.latency_min, want.latency_min);
                    if (got.latency_max != want.latency_max)
                        report_mismatch("latency_max", got.latency_max, want.latency_max);
                    if (got.latency_p95 != want.latency_p95)
                        report_mismatch("latency_p95", got.latency_p95, want.latency_p95);
                    if (got.latency_p99 != want.latency_p99)
                        report_mismatch("latency_p99", got.latency_p99, want.latency_p99);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    CMD_RECORD: add_request(i_s_tdata[15:0], i_s_tdata[63:16],
                                            i_s_tdata[95:64], i_s_tdata[127:96]);
                    CMD_CLEAR: clear_stats();
                    CMD_SNAPSHOT: begin
                        want.req_total      = req_cnt;
                        want.good_requests  = good_cnt;
                        want.bad_requests   = bad_cnt;
                        want.sent_total     = sent_sum;
                        want.received_total = recv_sum;
                        want.latency_total  = lat_sum;
                        want.latency_min    = lat_seen ? lat_lo : '0;
                        want.latency_max    = lat_seen ? lat_hi : '0;
                        rank_latencies(want.latency_p95, want.latency_p99);
                        snap_q.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_pending = snap_q.size();
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the request statistics block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb;
    import rls_pkg::*;

    // Enough for one full-ring snapshot several times over.
    localparam int CYCLE_LIMIT = 4000000;
    localparam int FILL_CAP    = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = CMD_RECORD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count, pending;
    int cycle_count = 0;
    // Both sides skip their idle gaps while this is set.
    bit no_idle   = 1'b0;
    // Asks the receiver for one long hold-off.
    bit long_hold = 1'b0;
    int recs_since_clear = 0;

    request_latency_statistics u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    rls_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[request_latency_statistics] ERROR");
            $finish;
        end
    end

    // Receiver: a random hold-off before each word, plus one long stall on request.
    initial begin
        int  gap;
        bit  taken;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            // Wait for the word to be taken; the check is made just after each falling edge.
            taken = 1'b0;
            while (!taken) begin
                #1 taken = m_tvalid;
                @(posedge i_clk);
                if (!taken) @(negedge i_clk);
            end
        end
    end

    // Offers one word after a random gap (none while no_idle is set) and returns right after its accepting edge.
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] status,
                             input logic [47:0] lat, input logic [31:0] b_out,
                             input logic [31:0] b_in);
        int gap;
        bit rdy;
        @(negedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tuser  = cmd;
        s_tdata  = {b_in, b_out, lat, status};
        s_tvalid = 1'b1;
        rdy = 1'b0;
        while (!rdy) begin
            #1 rdy = s_tready;
            @(posedge i_clk);
            if (!rdy) @(negedge i_clk);
        end
        if (cmd == CMD_RECORD) recs_since_clear++;
        if (cmd == CMD_CLEAR) recs_since_clear = 0;
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        send_word(cmd, 16'($urandom), 48'({$urandom, $urandom}), $urandom, $urandom);
    endtask

    function automatic logic [47:0] pick_latency();
        case ($urandom_range(0, 5))
            0: pick_latency = {1'b1, 47'({$urandom, $urandom})};
            1: pick_latency = '0;
            2: pick_latency = 48'($urandom_range(1, 20));
            3: pick_latency = {1'b0, {LAT_W{1'b1}}};
            4: pick_latency = 48'($urandom_range(0, 100000));
            default: pick_latency = 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [15:0] pick_status();
        case ($urandom_range(0, 5))
            0: pick_status = STATUS_GOOD_LO - 16'd1;
            1: pick_status = STATUS_GOOD_LO;
            2: pick_status = STATUS_GOOD_HI - 16'd1;
            3: pick_status = STATUS_GOOD_HI;
            4: pick_status = 16'($urandom_range(200, 399));
            default: pick_status = 16'($urandom);
        endcase
    endfunction

    task automatic send_record();
        send_word(CMD_RECORD, pick_status(), pick_latency(), $urandom, $urandom);
    endtask

    initial begin
        int pick;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty snapshot, status bounds, latency extremes, byte extremes.
        send_cmd(CMD_SNAPSHOT);
        send_word(CMD_RECORD, 16'd199, 48'h8000_0000_0000, 32'h0, 32'hFFFF_FFFF);
        send_word(CMD_RECORD, 16'd200, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_word(CMD_RECORD, 16'd399, 48'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_RECORD, 16'd400, 48'h7FFF_FFFF_FFFF, 32'h0, 32'h0);
        send_word(CMD_RECORD, 16'h0000, 48'h1, 32'h1, 32'h1);
        send_word(CMD_RECORD, 16'hFFFF, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_SNAPSHOT);
        // The unused command must leave every total untouched.
        send_cmd(CMD_UNUSED);
        send_cmd(CMD_SNAPSHOT);
        send_cmd(CMD_CLEAR);
        send_cmd(CMD_SNAPSHOT);
        // A lone negative latency: min and max both read zero, percentiles too.
        send_word(CMD_RECORD, 16'd500, 48'hFFFF_FFFF_FFFF, 32'd7, 32'd9);
        send_cmd(CMD_SNAPSHOT);
        send_word(CMD_RECORD, 16'd250, 48'd12345, 32'd1, 32'd2);
        send_cmd(CMD_SNAPSHOT);
        send_cmd(CMD_CLEAR);

        // Pressure: the receiver stalls while records and snapshots keep coming,
        // so the queue fills and the input is held off.
        long_hold = 1'b1;
        no_idle   = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2) send_cmd(CMD_SNAPSHOT);
            else send_record();
        end
        no_idle = 1'b0;
        // Sender waits until every outstanding snapshot has been returned.
        @(negedge i_clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        send_cmd(CMD_CLEAR);

        // Ring wrap: more records than the ring holds, then one full-ring snapshot.
        no_idle = 1'b1;
        for (int i = 0; i < 1100; i++) send_record();
        send_cmd(CMD_SNAPSHOT);
        no_idle = 1'b0;
        send_cmd(CMD_CLEAR);

        // Random part: the ring stays small so snapshots remain quick.
        for (int i = 0; i < 600; i++) begin
            if (i % 150 == 0) no_idle = ~no_idle;
            pick = $urandom_range(0, 99);
            if (recs_since_clear >= FILL_CAP) send_cmd(CMD_CLEAR);
            else if (pick < 75) send_record();
            else if (pick < 91) send_cmd(CMD_SNAPSHOT);
            else if (pick < 96) send_cmd(CMD_CLEAR);
            else send_cmd(CMD_UNUSED);
        end
        send_cmd(CMD_SNAPSHOT);
        @(negedge i_clk);
        s_tvalid = 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[request_latency_statistics] OK");
        end else begin
            $display("[request_latency_statistics] ERROR");
        end
        $finish;
    end

endmodule
